@@ rtl/pra_pkg.sv @@
// Shared types, constants and the arctangent table for the point rotation block.
package pra_pkg;

    localparam int COORD_WIDTH  = 32;
    localparam int ANGLE_WIDTH  = 26;
    localparam int ANGLE_CALC_W = ANGLE_WIDTH + 1;
    localparam int TRIG_WIDTH   = 32;
    localparam int TRIG_SHIFT   = 30;
    localparam int Z_WIDTH      = 25;
    localparam int CORDIC_STEPS = 23;

    typedef logic signed [TRIG_WIDTH-1:0] trig_t;
    typedef logic signed [Z_WIDTH-1:0]    zang_t;

    // CORDIC gain compensation, 0.60725 in Q.30.
    localparam trig_t CORDIC_GAIN = 32'sd652032874;

    // Angles in Q.16 degrees.
    localparam logic signed [ANGLE_CALC_W-1:0] DEG_90  = 27'sd5898240;
    localparam logic signed [ANGLE_CALC_W-1:0] DEG_180 = 27'sd11796480;
    localparam logic signed [ANGLE_CALC_W-1:0] DEG_360 = 27'sd23592960;

    // atan(2^-step) in Q.16 degrees.
    function automatic zang_t atan_deg(input int step);
        zang_t val;
        begin
            case (step)
                0:       val = 25'sd2949120;
                1:       val = 25'sd1740967;
                2:       val = 25'sd919879;
                3:       val = 25'sd466945;
                4:       val = 25'sd234379;
                5:       val = 25'sd117304;
                6:       val = 25'sd58666;
                7:       val = 25'sd29335;
                8:       val = 25'sd14668;
                9:       val = 25'sd7334;
                10:      val = 25'sd3667;
                11:      val = 25'sd1833;
                12:      val = 25'sd917;
                13:      val = 25'sd458;
                14:      val = 25'sd229;
                15:      val = 25'sd115;
                16:      val = 25'sd57;
                17:      val = 25'sd29;
                18:      val = 25'sd14;
                19:      val = 25'sd7;
                20:      val = 25'sd4;
                21:      val = 25'sd2;
                22:      val = 25'sd1;
                default: val = 25'sd0;
            endcase
            return val;
        end
    endfunction

endpackage

@@ rtl/pra_front.sv @@
// Input stage: angle reduction to plus or minus 90 degrees and pivot offset.
module pra_front #(
    parameter int CW = pra_pkg::COORD_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [CW-1:0]                   point_x,
    input  logic signed [CW-1:0]                   point_y,
    input  logic signed [CW-1:0]                   pivot_x,
    input  logic signed [CW-1:0]                   pivot_y,
    input  logic signed [pra_pkg::ANGLE_WIDTH-1:0] turn_degrees,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [CW:0]                     off_x,
    output logic signed [CW:0]                     off_y,
    output logic signed [CW-1:0]                   piv_x,
    output logic signed [CW-1:0]                   piv_y,
    output pra_pkg::zang_t                         angle
);

    logic signed [pra_pkg::ANGLE_CALC_W-1:0] z_wide;
    logic signed [pra_pkg::ANGLE_CALC_W-1:0] z_wrap;
    logic signed [pra_pkg::ANGLE_CALC_W-1:0] z_fold;
    logic                                    flip;
    logic signed [CW:0]                      px_e;
    logic signed [CW:0]                      py_e;
    logic signed [CW:0]                      cx_e;
    logic signed [CW:0]                      cy_e;
    logic                                    valid_reg;
    logic signed [CW:0]                      off_x_reg;
    logic signed [CW:0]                      off_y_reg;
    logic signed [CW-1:0]                    piv_x_reg;
    logic signed [CW-1:0]                    piv_y_reg;
    pra_pkg::zang_t                          angle_reg;

    always_comb
    begin
        z_wide = {turn_degrees[pra_pkg::ANGLE_WIDTH-1], turn_degrees};
        if (z_wide >= pra_pkg::DEG_180)
        begin
            z_wrap = z_wide - pra_pkg::DEG_360;
        end
        else if (z_wide < -pra_pkg::DEG_180)
        begin
            z_wrap = z_wide + pra_pkg::DEG_360;
        end
        else
        begin
            z_wrap = z_wide;
        end
        flip = 1'b0;
        if (z_wrap > pra_pkg::DEG_90)
        begin
            z_fold = z_wrap - pra_pkg::DEG_180;
            flip   = 1'b1;
        end
        else if (z_wrap < -pra_pkg::DEG_90)
        begin
            z_fold = z_wrap + pra_pkg::DEG_180;
            flip   = 1'b1;
        end
        else
        begin
            z_fold = z_wrap;
        end
    end

    // Negating the offset stands in for negating cosine and sine.
    assign px_e = {point_x[CW-1], point_x};
    assign py_e = {point_y[CW-1], point_y};
    assign cx_e = {pivot_x[CW-1], pivot_x};
    assign cy_e = {pivot_y[CW-1], pivot_y};

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            off_x_reg <= flip ? (cx_e - px_e) : (px_e - cx_e);
            off_y_reg <= flip ? (cy_e - py_e) : (py_e - cy_e);
            piv_x_reg <= pivot_x;
            piv_y_reg <= pivot_y;
            angle_reg <= z_fold[pra_pkg::Z_WIDTH-1:0];
        end
    end

    assign out_valid = valid_reg;
    assign off_x     = off_x_reg;
    assign off_y     = off_y_reg;
    assign piv_x     = piv_x_reg;
    assign piv_y     = piv_y_reg;
    assign angle     = angle_reg;

endmodule

@@ rtl/pra_cell.sv @@
// One CORDIC rotation cell; carries the point offset and pivot alongside.
module pra_cell #(
    parameter int CW   = pra_pkg::COORD_WIDTH,
    parameter int STEP = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pra_pkg::trig_t       x_in,
    input  pra_pkg::trig_t       y_in,
    input  pra_pkg::zang_t       z_in,
    input  logic signed [CW:0]   off_x_in,
    input  logic signed [CW:0]   off_y_in,
    input  logic signed [CW-1:0] piv_x_in,
    input  logic signed [CW-1:0] piv_y_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pra_pkg::trig_t       x_out,
    output pra_pkg::trig_t       y_out,
    output pra_pkg::zang_t       z_out,
    output logic signed [CW:0]   off_x_out,
    output logic signed [CW:0]   off_y_out,
    output logic signed [CW-1:0] piv_x_out,
    output logic signed [CW-1:0] piv_y_out
);

    localparam pra_pkg::zang_t ATAN_STEP = pra_pkg::atan_deg(STEP);

    pra_pkg::trig_t       x_shift;
    pra_pkg::trig_t       y_shift;
    pra_pkg::trig_t       x_next;
    pra_pkg::trig_t       y_next;
    pra_pkg::zang_t       z_next;
    logic                 valid_reg;
    pra_pkg::trig_t       x_reg;
    pra_pkg::trig_t       y_reg;
    pra_pkg::zang_t       z_reg;
    logic signed [CW:0]   off_x_reg;
    logic signed [CW:0]   off_y_reg;
    logic signed [CW-1:0] piv_x_reg;
    logic signed [CW-1:0] piv_y_reg;

    assign x_shift = x_in >>> STEP;
    assign y_shift = y_in >>> STEP;

    always_comb
    begin
        if (!z_in[pra_pkg::Z_WIDTH-1])
        begin
            x_next = x_in - y_shift;
            y_next = y_in + x_shift;
            z_next = z_in - ATAN_STEP;
        end
        else
        begin
            x_next = x_in + y_shift;
            y_next = y_in - x_shift;
            z_next = z_in + ATAN_STEP;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            off_x_reg <= off_x_in;
            off_y_reg <= off_y_in;
            piv_x_reg <= piv_x_in;
            piv_y_reg <= piv_y_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign off_x_out = off_x_reg;
    assign off_y_out = off_y_reg;
    assign piv_x_out = piv_x_reg;
    assign piv_y_out = piv_y_reg;

endmodule

@@ rtl/pra_mix.sv @@
// Rotation by cosine and sine, rounding, pivot add-back and saturation.
module pra_mix #(
    parameter int CW = pra_pkg::COORD_WIDTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [CW:0]   off_x,
    input  logic signed [CW:0]   off_y,
    input  pra_pkg::trig_t       cos_v,
    input  pra_pkg::trig_t       sin_v,
    input  logic signed [CW-1:0] piv_x,
    input  logic signed [CW-1:0] piv_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [CW-1:0] turned_x,
    output logic signed [CW-1:0] turned_y,
    output logic                 overflow
);

    localparam int TW    = pra_pkg::TRIG_WIDTH;
    localparam int DW    = CW + 1;
    localparam int LO_W  = DW / 2;
    localparam int HI_W  = DW - LO_W;
    localparam int HIP_W = HI_W + TW;
    localparam int LOP_W = LO_W + 1 + TW;
    localparam int FW    = DW + TW;
    localparam int SW    = FW + 1;
    localparam int QW    = SW - pra_pkg::TRIG_SHIFT;
    localparam int RW    = QW + 1;

    localparam logic signed [SW-1:0] ROUND_HALF =
        {{(SW - pra_pkg::TRIG_SHIFT){1'b0}}, 1'b1, {(pra_pkg::TRIG_SHIFT - 1){1'b0}}};
    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW - 1){1'b0}}};

    logic signed [HI_W-1:0]  dx_hi;
    logic signed [HI_W-1:0]  dy_hi;
    logic signed [LO_W:0]    dx_lo;
    logic signed [LO_W:0]    dy_lo;

    logic                    v1_reg;
    logic signed [HIP_W-1:0] xc_hi_reg;
    logic signed [LOP_W-1:0] xc_lo_reg;
    logic signed [HIP_W-1:0] ys_hi_reg;
    logic signed [LOP_W-1:0] ys_lo_reg;
    logic signed [HIP_W-1:0] xs_hi_reg;
    logic signed [LOP_W-1:0] xs_lo_reg;
    logic signed [HIP_W-1:0] yc_hi_reg;
    logic signed [LOP_W-1:0] yc_lo_reg;
    logic signed [CW-1:0]    cx1_reg;
    logic signed [CW-1:0]    cy1_reg;
    logic                    ready1;

    logic signed [FW-1:0]    f_xc;
    logic signed [FW-1:0]    f_ys;
    logic signed [FW-1:0]    f_xs;
    logic signed [FW-1:0]    f_yc;
    logic signed [SW-1:0]    sum_x_next;
    logic signed [SW-1:0]    sum_y_next;
    logic                    v2_reg;
    logic signed [SW-1:0]    sum_x_reg;
    logic signed [SW-1:0]    sum_y_reg;
    logic signed [CW-1:0]    cx2_reg;
    logic signed [CW-1:0]    cy2_reg;
    logic                    ready2;

    logic signed [RW-1:0]    r_x;
    logic signed [RW-1:0]    r_y;
    logic                    fit_x;
    logic                    fit_y;
    logic signed [CW-1:0]    sat_x_next;
    logic signed [CW-1:0]    sat_y_next;
    logic                    v3_reg;
    logic signed [CW-1:0]    rx_reg;
    logic signed [CW-1:0]    ry_reg;
    logic                    ovf_reg;
    logic                    ready3;

    // The offset is split into a signed upper part and an unsigned lower part.
    assign dx_hi = off_x[DW-1:LO_W];
    assign dy_hi = off_y[DW-1:LO_W];
    assign dx_lo = {1'b0, off_x[LO_W-1:0]};
    assign dy_lo = {1'b0, off_y[LO_W-1:0]};

    assign ready3   = !v3_reg || out_ready;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            xc_hi_reg <= dx_hi * cos_v;
            xc_lo_reg <= dx_lo * cos_v;
            ys_hi_reg <= dy_hi * sin_v;
            ys_lo_reg <= dy_lo * sin_v;
            xs_hi_reg <= dx_hi * sin_v;
            xs_lo_reg <= dx_lo * sin_v;
            yc_hi_reg <= dy_hi * cos_v;
            yc_lo_reg <= dy_lo * cos_v;
            cx1_reg   <= piv_x;
            cy1_reg   <= piv_y;
        end
    end

    assign f_xc = {xc_hi_reg, {LO_W{1'b0}}} + {{(FW - LOP_W){xc_lo_reg[LOP_W-1]}}, xc_lo_reg};
    assign f_ys = {ys_hi_reg, {LO_W{1'b0}}} + {{(FW - LOP_W){ys_lo_reg[LOP_W-1]}}, ys_lo_reg};
    assign f_xs = {xs_hi_reg, {LO_W{1'b0}}} + {{(FW - LOP_W){xs_lo_reg[LOP_W-1]}}, xs_lo_reg};
    assign f_yc = {yc_hi_reg, {LO_W{1'b0}}} + {{(FW - LOP_W){yc_lo_reg[LOP_W-1]}}, yc_lo_reg};

    assign sum_x_next = {f_xc[FW-1], f_xc} - {f_ys[FW-1], f_ys} + ROUND_HALF;
    assign sum_y_next = {f_xs[FW-1], f_xs} + {f_yc[FW-1], f_yc} + ROUND_HALF;

    always_ff @(posedge clk)
    begin
        if (ready2 && v1_reg)
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
        end
    end

    assign r_x = {sum_x_reg[SW-1], sum_x_reg[SW-1:pra_pkg::TRIG_SHIFT]}
               + {{(RW - CW){cx2_reg[CW-1]}}, cx2_reg};
    assign r_y = {sum_y_reg[SW-1], sum_y_reg[SW-1:pra_pkg::TRIG_SHIFT]}
               + {{(RW - CW){cy2_reg[CW-1]}}, cy2_reg};

    assign fit_x = (&r_x[RW-1:CW-1]) || !(|r_x[RW-1:CW-1]);
    assign fit_y = (&r_y[RW-1:CW-1]) || !(|r_y[RW-1:CW-1]);

    assign sat_x_next = fit_x ? r_x[CW-1:0] : (r_x[RW-1] ? COORD_MIN : COORD_MAX);
    assign sat_y_next = fit_y ? r_y[CW-1:0] : (r_y[RW-1] ? COORD_MIN : COORD_MAX);

    always_ff @(posedge clk)
    begin
        if (ready3 && v2_reg)
        begin
            rx_reg  <= sat_x_next;
            ry_reg  <= sat_y_next;
            ovf_reg <= !(fit_x && fit_y);
        end
    end

    assign out_valid = v3_reg;
    assign turned_x  = rx_reg;
    assign turned_y  = ry_reg;
    assign overflow  = ovf_reg;

endmodule

@@ rtl/point_rotate_about_center.sv @@
// Top level of the point rotation block: rotates a point about a pivot by an angle.
// The path from an accepted input word to its output word runs through one input stage,
// 23 CORDIC cells and three stages of multiply, sum and saturate.
// Throughput is one word per cycle while m_axis_tready is high; every stage holds its word only while the next is full.
// Reset (rst_n low, asynchronous) empties the pipeline; data registers are not cleared.
module point_rotate_about_center #(
    parameter int COORD_WIDTH = pra_pkg::COORD_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // point_x, point_y, pivot_x, pivot_y, turn_degrees, zero fill
    input  logic [((4 * COORD_WIDTH + pra_pkg::ANGLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // turned_x, turned_y, zero fill
    output logic [((2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // overflow
    output logic [0:0]              m_axis_tuser
);

    localparam int CW    = COORD_WIDTH;
    localparam int AW    = pra_pkg::ANGLE_WIDTH;
    localparam int STEPS = pra_pkg::CORDIC_STEPS;
    localparam int OUT_W = ((2 * COORD_WIDTH + 7) / 8) * 8;

    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] pivot_x;
    logic signed [CW-1:0] pivot_y;
    logic signed [AW-1:0] turn_degrees;

    logic                 cell_valid [0:STEPS];
    logic                 cell_ready [0:STEPS];
    pra_pkg::trig_t       cell_x     [0:STEPS];
    pra_pkg::trig_t       cell_y     [0:STEPS];
    pra_pkg::zang_t       cell_z     [0:STEPS];
    logic signed [CW:0]   cell_dx    [0:STEPS];
    logic signed [CW:0]   cell_dy    [0:STEPS];
    logic signed [CW-1:0] cell_px    [0:STEPS];
    logic signed [CW-1:0] cell_py    [0:STEPS];

    logic signed [CW-1:0] turned_x;
    logic signed [CW-1:0] turned_y;
    logic                 overflow;

    assign point_x      = s_axis_tdata[CW-1:0];
    assign point_y      = s_axis_tdata[2*CW-1:CW];
    assign pivot_x      = s_axis_tdata[3*CW-1:2*CW];
    assign pivot_y      = s_axis_tdata[4*CW-1:3*CW];
    assign turn_degrees = s_axis_tdata[4*CW+AW-1:4*CW];

    pra_front #(
        .CW(CW)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .point_x      (point_x),
        .point_y      (point_y),
        .pivot_x      (pivot_x),
        .pivot_y      (pivot_y),
        .turn_degrees (turn_degrees),
        .out_valid    (cell_valid[0]),
        .out_ready    (cell_ready[0]),
        .off_x        (cell_dx[0]),
        .off_y        (cell_dy[0]),
        .piv_x        (cell_px[0]),
        .piv_y        (cell_py[0]),
        .angle        (cell_z[0])
    );

    assign cell_x[0] = pra_pkg::CORDIC_GAIN;
    assign cell_y[0] = '0;

    for (genvar g = 0; g < STEPS; g++)
    begin : g_cell
        pra_cell #(
            .CW   (CW),
            .STEP (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cell_valid[g]),
            .in_ready  (cell_ready[g]),
            .x_in      (cell_x[g]),
            .y_in      (cell_y[g]),
            .z_in      (cell_z[g]),
            .off_x_in  (cell_dx[g]),
            .off_y_in  (cell_dy[g]),
            .piv_x_in  (cell_px[g]),
            .piv_y_in  (cell_py[g]),
            .out_valid (cell_valid[g+1]),
            .out_ready (cell_ready[g+1]),
            .x_out     (cell_x[g+1]),
            .y_out     (cell_y[g+1]),
            .z_out     (cell_z[g+1]),
            .off_x_out (cell_dx[g+1]),
            .off_y_out (cell_dy[g+1]),
            .piv_x_out (cell_px[g+1]),
            .piv_y_out (cell_py[g+1])
        );
    end

    pra_mix #(
        .CW(CW)
    ) u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cell_valid[STEPS]),
        .in_ready  (cell_ready[STEPS]),
        .off_x     (cell_dx[STEPS]),
        .off_y     (cell_dy[STEPS]),
        .cos_v     (cell_x[STEPS]),
        .sin_v     (cell_y[STEPS]),
        .piv_x     (cell_px[STEPS]),
        .piv_y     (cell_py[STEPS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .turned_x  (turned_x),
        .turned_y  (turned_y),
        .overflow  (overflow)
    );

    assign m_axis_tdata = OUT_W'({turned_y, turned_x});
    assign m_axis_tuser = overflow;

endmodule
